/* design/ed_pkg.sv */
`default_nettype none

package ed_pkg;

    localparam int MAX_CARS_DEF = 8;

    localparam int FLOOR_W  = 8;
    localparam int RIDERS_W = 8;
    localparam int CAR_W    = 3;
    localparam int ACTIVE_W = 4;
    localparam int SCORE_W  = 14;   // worst case 1000 + 5000 + 2550

    localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 4'd8;

    localparam logic [SCORE_W-1:0] SCORE_BASE     = 14'd1000;
    localparam logic [SCORE_W-1:0] SCORE_BUSY     = 14'd5000;
    localparam logic [SCORE_W-1:0] BONUS_SAME_DIR = 14'd500;
    localparam logic [SCORE_W-1:0] BONUS_ABOVE    = 14'd400;
    localparam logic [SCORE_W-1:0] BONUS_REST     = 14'd300;

    typedef enum logic [1:0] {
        OP_HALL   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MOT_UP   = 2'd0,
        MOT_DOWN = 2'd1,
        MOT_REST = 2'd2
    } motion_t;

    // motion code on an update that leaves the stored motion alone
    localparam logic [1:0] MOTION_KEEP = 2'd3;

    typedef struct packed {
        logic [FLOOR_W-1:0]  floor;
        logic [1:0]          motion;
        logic                busy;
        logic                removed;
        logic [RIDERS_W-1:0] passengers;
    } car_entry_t;

    localparam car_entry_t CAR_RESET = '{
        floor:      8'd1,
        motion:     MOT_REST,
        busy:       1'b0,
        removed:    1'b0,
        passengers: 8'd0
    };

endpackage

`default_nettype wire

/* design/ed_ifs.sv */
`default_nettype none

interface ed_req_if import ed_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic [CAR_W-1:0]    car_id;
    logic [FLOOR_W-1:0]  floor;
    logic                going_up;
    logic [1:0]          motion_code;
    logic [RIDERS_W-1:0] riders;
    logic                riders_valid;
    logic                trip_done;

    modport source (
        output valid, op, car_id, floor, going_up, motion_code, riders, riders_valid,
               trip_done,
        input  ready
    );
    modport sink (
        input  valid, op, car_id, floor, going_up, motion_code, riders, riders_valid,
               trip_done,
        output ready
    );
endinterface

interface ed_rsp_if import ed_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAR_W-1:0] assigned_car;
    logic             assign_valid;
    logic             used_fallback;

    modport source (
        output valid, assigned_car, assign_valid, used_fallback,
        input  ready
    );
    modport sink (
        input  valid, assigned_car, assign_valid, used_fallback,
        output ready
    );
endinterface

`default_nettype wire

/* design/ed_car_mem.sv */
`default_nettype none

// Car table: one word per car, registered read, one write port.
// Entries not yet written read back as the reset entry.
module ed_car_mem import ed_pkg::*; #(
    parameter int MAX_CARS = MAX_CARS_DEF,
    localparam int CW = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd_en,
    input  wire logic [CW-1:0]        rd_addr,
    output car_entry_t                rd_data,
    input  wire logic                 wr_en,
    input  wire logic [CW-1:0]        wr_addr,
    input  wire car_entry_t           wr_data
);
    car_entry_t            mem [MAX_CARS];
    logic [MAX_CARS-1:0]   written_reg;
    car_entry_t            rd_word_reg;
    logic                  rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_written_reg ? rd_word_reg : CAR_RESET;

endmodule

`default_nettype wire

/* design/ed_score.sv */
`default_nettype none

// One registered scoring stage: score of one car against the hall call.
module ed_score import ed_pkg::*; #(
    parameter int MAX_CARS = MAX_CARS_DEF,
    localparam int CW = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_vld,
    input  wire logic [CW-1:0]       in_idx,
    input  wire car_entry_t          in_entry,
    input  wire logic [FLOOR_W-1:0]  origin,
    input  wire logic                going_up,
    output logic                     sc_vld,
    output logic [CW-1:0]            sc_idx,
    output logic [SCORE_W-1:0]       sc_score,
    output car_entry_t               sc_entry
);
    logic [FLOOR_W-1:0]  span;
    logic [11:0]         span_x10;
    logic [SCORE_W-1:0]  base;
    logic [SCORE_W-1:0]  bonus;
    logic                below_or_at;
    logic                above_or_at;
    logic                above;

    logic                vld_reg;
    logic [CW-1:0]       idx_reg;
    logic [SCORE_W-1:0]  score_reg;
    car_entry_t          entry_reg;

    always_comb
    begin
        above       = in_entry.floor > origin;
        below_or_at = !above;
        above_or_at = in_entry.floor >= origin;
        span        = above ? (in_entry.floor - origin) : (origin - in_entry.floor);
        span_x10    = 12'({span, 3'b000}) + 12'({span, 1'b0});
        base        = SCORE_BASE + (in_entry.busy ? SCORE_BUSY : '0) + SCORE_W'(span_x10);
        if (going_up)
        begin
            priority if (in_entry.motion == MOT_UP && below_or_at) bonus = BONUS_SAME_DIR;
            else if (in_entry.motion == MOT_REST)                  bonus = BONUS_REST;
            else                                                   bonus = '0;
        end
        else
        begin
            priority if (in_entry.motion == MOT_DOWN && above_or_at) bonus = BONUS_SAME_DIR;
            else if (above)                                          bonus = BONUS_ABOVE;
            else if (in_entry.motion == MOT_REST)                    bonus = BONUS_REST;
            else                                                     bonus = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= in_idx;
        score_reg <= base - bonus;
        entry_reg <= in_entry;
    end

    assign sc_vld   = vld_reg;
    assign sc_idx   = idx_reg;
    assign sc_score = score_reg;
    assign sc_entry = entry_reg;

endmodule

`default_nettype wire

/* design/elevator_dispatch_scorer.sv */
// Elevator dispatch scorer.
// req channel (valid/ready): one beat is one operation - a hall call, a car
// status update or a car removal. rsp channel (valid/ready): exactly one beat
// per request beat, in order; for a hall call it carries the chosen car and
// whether round robin picked it, otherwise all zero.
// cfg_wr_en/cfg_wr_data write the active car count; write it only while idle.
// The car table sits in a small RAM with a registered read; every update,
// removal and hall call is a read-modify-write of it, one operation at a time.
// An update or removal reads the car and writes it back. A hall call reads
// the scanned cars one RAM read a cycle, drains the scoring pipe, writes the
// winner back and loads the result slot; if every scanned car is removed,
// round robin re-reads its pick and writes it back instead. Unused op codes
// and out-of-range cars touch no RAM and go straight to the result.
// A hall call's length is set by the single RAM port, one car read at a time.
// The result register frees the request side: a new request beat is taken
// while the last result still waits on a stalled receiver; the block only
// holds its finished result until the slot is free.
// Reset: all cars at floor 1, at rest, idle, in service, empty; round robin
// points so that its first pick is car 0; active count 8. No clearing pass.
`default_nettype none

module elevator_dispatch_scorer import ed_pkg::*; #(
    parameter int MAX_CARS = MAX_CARS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    ed_req_if.sink                    req,
    ed_rsp_if.source                  rsp,
    input  wire logic                 cfg_wr_en,
    input  wire logic [ACTIVE_W-1:0]  cfg_wr_data
);
    localparam int CW = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
    localparam int EW = CW + CAR_W + ACTIVE_W;   // wide enough for any index move

    typedef enum logic [2:0] {
        S_IDLE,
        S_RMW_RD,
        S_RMW_WR,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_FB_RD,
        S_FB_WR
    } state_t;

    // S_DONE folded in as a flag so the FSM stays small
    state_t               state_reg;
    logic                 done_reg;

    logic [ACTIVE_W-1:0]  cfg_active_reg;
    logic [CW-1:0]        rr_reg;

    // latched request
    logic [1:0]           op_reg;
    logic [CW-1:0]        car_idx_reg;
    logic [FLOOR_W-1:0]   floor_reg;
    logic                 up_reg;
    logic [1:0]           motion_reg;
    logic [RIDERS_W-1:0]  riders_reg;
    logic                 riders_ok_reg;
    logic                 trip_done_reg;

    // scan
    logic [CW-1:0]        scan_idx_reg;
    logic [CW-1:0]        scan_last_reg;
    logic                 p1_vld_reg;
    logic [CW-1:0]        p1_idx_reg;
    logic                 best_found_reg;
    logic [SCORE_W-1:0]   best_score_reg;
    logic [CW-1:0]        best_idx_reg;
    car_entry_t           best_entry_reg;

    // pending result and output slot
    logic [CW-1:0]        res_car_reg;
    logic                 res_assign_reg;
    logic                 res_fb_reg;
    logic                 out_vld_reg;
    logic [CAR_W-1:0]     out_car_reg;
    logic                 out_assign_reg;
    logic                 out_fb_reg;

    // RAM ports
    logic                 mem_rd_en;
    logic [CW-1:0]        mem_rd_addr;
    car_entry_t           mem_rd_data;
    logic                 mem_wr_en;
    logic [CW-1:0]        mem_wr_addr;
    car_entry_t           mem_wr_data;

    // scorer
    logic                 sc_vld;
    logic [CW-1:0]        sc_idx;
    logic [SCORE_W-1:0]   sc_score;
    car_entry_t           sc_entry;

    logic [EW-1:0]        id_ext;
    logic [EW-1:0]        last_ext;
    logic [EW-1:0]        res_ext;
    logic [CW-1:0]        req_idx;
    logic                 req_id_ok;
    logic [CW-1:0]        req_last;
    logic [CW-1:0]        rr_next;
    logic                 out_free;
    logic                 load_out;
    car_entry_t           upd_entry;

    ed_car_mem #(
        .MAX_CARS (MAX_CARS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    ed_score #(
        .MAX_CARS (MAX_CARS)
    ) u_score (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (p1_vld_reg),
        .in_idx   (p1_idx_reg),
        .in_entry (mem_rd_data),
        .origin   (floor_reg),
        .going_up (up_reg),
        .sc_vld   (sc_vld),
        .sc_idx   (sc_idx),
        .sc_score (sc_score),
        .sc_entry (sc_entry)
    );

    // index and count conversions
    always_comb
    begin
        id_ext    = EW'(req.car_id);
        req_idx   = id_ext[CW-1:0];
        req_id_ok = 32'(req.car_id) < 32'(MAX_CARS);
        // scan count clamped to 1 .. MAX_CARS, kept as last index
        last_ext  = EW'(cfg_active_reg - 4'd1);
        if (cfg_active_reg == '0)
        begin
            req_last = '0;
        end
        else if (32'(cfg_active_reg) > 32'(MAX_CARS))
        begin
            req_last = CW'(MAX_CARS - 1);
        end
        else
        begin
            req_last = last_ext[CW-1:0];
        end
        rr_next  = (rr_reg >= scan_last_reg) ? '0 : rr_reg + CW'(1);
        res_ext  = EW'(res_car_reg);
        out_free = !out_vld_reg || rsp.ready;
        // finished result moves into the output slot
        load_out = (state_reg == S_IDLE) && done_reg && out_free;
    end

    // status update / removal applied to the word just read
    always_comb
    begin
        upd_entry = mem_rd_data;
        if (op_reg == OP_REMOVE)
        begin
            upd_entry.removed = 1'b1;
        end
        else
        begin
            upd_entry.floor = floor_reg;
            if (riders_ok_reg)
            begin
                upd_entry.passengers = riders_reg;
            end
            if (motion_reg != MOTION_KEEP)
            begin
                upd_entry.motion = motion_reg;
            end
            if (trip_done_reg)
            begin
                upd_entry.busy = 1'b0;
            end
        end
    end

    // RAM port steering
    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = scan_idx_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = car_idx_reg;
        mem_wr_data = upd_entry;
        unique case (state_reg)
            S_RMW_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = car_idx_reg;
            end
            S_RMW_WR:
            begin
                mem_wr_en = 1'b1;
            end
            S_SCAN:
            begin
                mem_rd_en = 1'b1;
            end
            S_COMMIT:
            begin
                mem_wr_en        = 1'b1;
                mem_wr_addr      = best_idx_reg;
                mem_wr_data      = best_entry_reg;
                mem_wr_data.busy = 1'b1;
            end
            S_FB_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = rr_reg;
            end
            S_FB_WR:
            begin
                mem_wr_en        = 1'b1;
                mem_wr_addr      = rr_reg;
                mem_wr_data      = mem_rd_data;
                mem_wr_data.busy = 1'b1;
            end
            default:
            begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            cfg_active_reg <= ACTIVE_RST;
            rr_reg         <= CW'(MAX_CARS - 1);
            op_reg         <= '0;
            car_idx_reg    <= '0;
            floor_reg      <= '0;
            up_reg         <= 1'b0;
            motion_reg     <= '0;
            riders_reg     <= '0;
            riders_ok_reg  <= 1'b0;
            trip_done_reg  <= 1'b0;
            scan_idx_reg   <= '0;
            scan_last_reg  <= '0;
            p1_vld_reg     <= 1'b0;
            p1_idx_reg     <= '0;
            best_found_reg <= 1'b0;
            best_score_reg <= '0;
            best_idx_reg   <= '0;
            best_entry_reg <= CAR_RESET;
            res_car_reg    <= '0;
            res_assign_reg <= 1'b0;
            res_fb_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            out_car_reg    <= '0;
            out_assign_reg <= 1'b0;
            out_fb_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_active_reg <= cfg_wr_data;
            end

            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            p1_vld_reg <= (state_reg == S_SCAN);
            p1_idx_reg <= scan_idx_reg;

            // running minimum; strict less keeps the lowest index on a tie
            if (sc_vld && !sc_entry.removed &&
                (!best_found_reg || sc_score < best_score_reg))
            begin
                best_found_reg <= 1'b1;
                best_score_reg <= sc_score;
                best_idx_reg   <= sc_idx;
                best_entry_reg <= sc_entry;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (done_reg)
                    begin
                        if (out_free)
                        begin
                            out_car_reg    <= res_ext[CAR_W-1:0];
                            out_assign_reg <= res_assign_reg;
                            out_fb_reg     <= res_fb_reg;
                            done_reg       <= 1'b0;
                        end
                    end
                    else if (req.valid)
                    begin
                        op_reg         <= req.op;
                        car_idx_reg    <= req_idx;
                        floor_reg      <= req.floor;
                        up_reg         <= req.going_up;
                        motion_reg     <= req.motion_code;
                        riders_reg     <= req.riders;
                        riders_ok_reg  <= req.riders_valid;
                        trip_done_reg  <= req.trip_done;
                        scan_idx_reg   <= '0;
                        scan_last_reg  <= req_last;
                        best_found_reg <= 1'b0;
                        res_car_reg    <= '0;
                        res_assign_reg <= 1'b0;
                        res_fb_reg     <= 1'b0;
                        unique case (req.op)
                            OP_HALL:
                            begin
                                state_reg <= S_SCAN;
                            end
                            OP_UPDATE, OP_REMOVE:
                            begin
                                if (req_id_ok)
                                begin
                                    state_reg <= S_RMW_RD;
                                end
                                else
                                begin
                                    done_reg <= 1'b1;
                                end
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RMW_RD:
                begin
                    state_reg <= S_RMW_WR;
                end
                S_RMW_WR:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                S_SCAN:
                begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                    if (scan_idx_reg == scan_last_reg)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!p1_vld_reg && !sc_vld)
                    begin
                        res_assign_reg <= 1'b1;
                        if (best_found_reg)
                        begin
                            res_car_reg <= best_idx_reg;
                            state_reg   <= S_COMMIT;
                        end
                        else
                        begin
                            rr_reg      <= rr_next;
                            res_car_reg <= rr_next;
                            res_fb_reg  <= 1'b1;
                            state_reg   <= S_FB_RD;
                        end
                    end
                end
                S_COMMIT:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                S_FB_RD:
                begin
                    state_reg <= S_FB_WR;
                end
                S_FB_WR:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready         = (state_reg == S_IDLE) && !done_reg;
    assign rsp.valid         = out_vld_reg;
    assign rsp.assigned_car  = out_car_reg;
    assign rsp.assign_valid  = out_assign_reg;
    assign rsp.used_fallback = out_fb_reg;

    // a new beat is only taken with the scoring pipe empty
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (!p1_vld_reg && !sc_vld))
        else $error("request taken with scoring pipe busy");

    // round robin only ever answers a hall call
    a_fb_is_hall: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.used_fallback) |-> rsp.assign_valid)
        else $error("fallback flagged on a non-hall result");

    // write-back of a scored winner needs a winner
    a_commit_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |-> best_found_reg)
        else $error("commit without a scored car");

    // every hall-call write-back marks the car busy
    a_hall_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && state_reg != S_RMW_WR) |-> mem_wr_data.busy)
        else $error("assigned car not marked busy");

endmodule

`default_nettype wire

/* tb/ed_checker.sv */
`default_nettype none

module ed_checker import ed_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    ed_req_if                        req,
    ed_rsp_if                        rsp,
    input  wire logic                cfg_wr_en,
    input  wire logic [ACTIVE_W-1:0] cfg_wr_data,
    output int                       fail_count,
    output int                       awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CAR_W-1:0] car;
        logic             assign_valid;
        logic             fallback;
    } dispatch_t;

    car_entry_t        car_tab [MAX_CARS_DEF];
    logic [ACTIVE_W-1:0] active_reg;
    logic [CAR_W-1:0]  rr_last;
    dispatch_t         dispatch_q [$];

    task automatic report(string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // 0 behaves as 1, anything past the table size as the table size
    function automatic int cars_scanned();
        int n;
        n = int'(active_reg);
        if (n < 1) n = 1;
        if (n > MAX_CARS_DEF) n = MAX_CARS_DEF;
        return n;
    endfunction

    function automatic int hall_score(int c, int origin, logic up);
        int pos;
        int span;
        int s;
        pos  = int'(car_tab[c].floor);
        span = (pos > origin) ? pos - origin : origin - pos;
        s    = int'(SCORE_BASE) + 10 * span;
        if (car_tab[c].busy) s += int'(SCORE_BUSY);
        if (up) begin
            if (car_tab[c].motion == MOT_UP && pos <= origin) s -= int'(BONUS_SAME_DIR);
            else if (car_tab[c].motion == MOT_REST) s -= int'(BONUS_REST);
        end
        else begin
            if (car_tab[c].motion == MOT_DOWN && pos >= origin) s -= int'(BONUS_SAME_DIR);
            else if (pos > origin) s -= int'(BONUS_ABOVE);
            else if (car_tab[c].motion == MOT_REST) s -= int'(BONUS_REST);
        end
        return s;
    endfunction

    // applies one request beat to the car table, returns the dispatch it yields
    function automatic dispatch_t apply_beat(logic [1:0] op, logic [CAR_W-1:0] id,
                                             logic [FLOOR_W-1:0] flr, logic up,
                                             logic [1:0] mcode, logic [RIDERS_W-1:0] riders,
                                             logic riders_ok, logic done);
        dispatch_t res;
        int        n;
        int        best;
        int        best_score;
        int        s;
        int        nxt;
        logic      found;
        res = '0;
        if (op == OP_HALL) begin
            n          = cars_scanned();
            best       = 0;
            best_score = 1000000000;
            found      = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!car_tab[i].removed) begin
                    s = hall_score(i, int'(flr), up);
                    if (s < best_score) begin
                        best_score = s;
                        best       = i;
                        found      = 1'b1;
                    end
                end
            end
            if (!found) begin
                nxt = int'(rr_last) + 1;
                if (nxt >= n) nxt = 0;
                best         = nxt;
                rr_last      = nxt[CAR_W-1:0];
                res.fallback = 1'b1;
            end
            car_tab[best].busy = 1'b1;
            res.car            = best[CAR_W-1:0];
            res.assign_valid   = 1'b1;
        end
        else if (op == OP_UPDATE) begin
            car_tab[id].floor = flr;
            if (riders_ok) car_tab[id].passengers = riders;
            if (mcode != MOTION_KEEP) car_tab[id].motion = mcode;
            if (done) car_tab[id].busy = 1'b0;
        end
        else if (op == OP_REMOVE) begin
            car_tab[id].removed = 1'b1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        dispatch_t want;
        if (!rst_n) begin
            for (int i = 0; i < MAX_CARS_DEF; i++) car_tab[i] = CAR_RESET;
            active_reg = ACTIVE_RST;
            rr_last    = CAR_W'(MAX_CARS_DEF - 1);
            dispatch_q.delete();
            fail_count = 0;
            awaiting   = 0;
        end
        else begin
            if (rsp.valid && rsp.ready) begin
                if (dispatch_q.size() == 0) begin
                    report($sformatf("result beat with none outstanding (car %0d)",
                                     rsp.assigned_car));
                end
                else begin
                    want = dispatch_q.pop_front();
                    if (rsp.assigned_car !== want.car)
                        report($sformatf("assigned_car %0d, want %0d",
                                         rsp.assigned_car, want.car));
                    if (rsp.assign_valid !== want.assign_valid)
                        report($sformatf("assign_valid %0b, want %0b",
                                         rsp.assign_valid, want.assign_valid));
                    if (rsp.used_fallback !== want.fallback)
                        report($sformatf("used_fallback %0b, want %0b",
                                         rsp.used_fallback, want.fallback));
                end
            end
            if (req.valid && req.ready)
                dispatch_q = {dispatch_q,
                              apply_beat(req.op, req.car_id, req.floor, req.going_up,
                                         req.motion_code, req.riders, req.riders_valid,
                                         req.trip_done)};
            if (cfg_wr_en) active_reg = cfg_wr_data;
            awaiting = dispatch_q.size();
        end
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ed_pkg::*;

    // op code the block must treat as a no-op with an all-zero result
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // cycles without any beat before we give up; far more than the slowest
    // item plus a full sender gap and a full receiver stall
    localparam int IDLE_LIMIT = 2000;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [ACTIVE_W-1:0] cfg_wr_data;
    int                  fail_count;
    int                  awaiting;
    int                  idle_cycles = 0;

    // pressure controls: gap_on/stall_on are re-rolled per phase so some
    // phases run back to back; quiet switches all idling off for the tail
    logic gap_on   = 1'b1;
    logic stall_on = 1'b1;
    logic quiet    = 1'b0;

    ed_req_if req_if ();
    ed_rsp_if rsp_if ();

    elevator_dispatch_scorer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    ed_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .awaiting    (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: any beat on either channel counts as progress. A lost result
    // or a hung handshake leaves the counter running until it trips.
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: holds ready low in random bursts, changing only on
    // the falling edge so the block sees a settled value at the rising edge.
    initial
    begin
        rsp_if.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!quiet && stall_on && $urandom_range(0, 5) == 0)
            begin
                rsp_if.ready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            rsp_if.ready = 1'b1;
        end
    end

    task automatic roll_pressure();
        gap_on   = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
    endtask

    // Drives one request beat and returns at the rising edge that takes it.
    // valid stays high afterwards unless a gap or a register write follows,
    // so back-to-back beats never see valid dropped and raised in one step.
    task automatic send_beat(logic [1:0] op, logic [CAR_W-1:0] id, logic [FLOOR_W-1:0] flr,
                             logic up, logic [1:0] mcode, logic [RIDERS_W-1:0] riders,
                             logic riders_ok, logic done);
        if (!quiet && gap_on && $urandom_range(0, 4) == 0)
        begin
            @(negedge clk);
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clk);
        end
        @(negedge clk);
        req_if.valid        = 1'b1;
        req_if.op           = op;
        req_if.car_id       = id;
        req_if.floor        = flr;
        req_if.going_up     = up;
        req_if.motion_code  = mcode;
        req_if.riders       = riders;
        req_if.riders_valid = riders_ok;
        req_if.trip_done    = done;
        do @(posedge clk); while (!req_if.ready);
    endtask

    // Active count may only change while the block is idle: drop valid,
    // let every outstanding dispatch drain, allow the write-back to settle.
    task automatic write_active(logic [ACTIVE_W-1:0] v);
        @(negedge clk);
        req_if.valid = 1'b0;
        while (awaiting != 0) @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    // Mostly hall calls and status updates with floors bunched low, so
    // distances stay comparable with the direction bonuses and ties occur.
    // Removals are rare and only hit cars 5..7 (cars 0..4 stay in service
    // until the round-robin phases take them out deliberately).
    task automatic random_run(int count, int remove_pct);
        int                 r;
        logic [1:0]         op;
        logic [CAR_W-1:0]   id;
        logic [FLOOR_W-1:0] flr;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < remove_pct)      op = OP_REMOVE;
            else if (r < 45)         op = OP_HALL;
            else if (r < 95)         op = OP_UPDATE;
            else                     op = OP_UNUSED;
            id  = (op == OP_REMOVE) ? CAR_W'($urandom_range(5, 7))
                                    : CAR_W'($urandom_range(0, 7));
            flr = ($urandom_range(0, 3) == 0) ? FLOOR_W'($urandom_range(0, 255))
                                              : FLOOR_W'($urandom_range(0, 15));
            send_beat(op, id, flr, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                      RIDERS_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        req_if.valid        = 1'b0;
        req_if.op           = OP_HALL;
        req_if.car_id       = '0;
        req_if.floor        = '0;
        req_if.going_up     = 1'b0;
        req_if.motion_code  = MOT_REST;
        req_if.riders       = '0;
        req_if.riders_valid = 1'b0;
        req_if.trip_done    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed, eight cars from reset ---
        // all cars alike at floor 1: tie goes to car 0
        send_beat(OP_HALL, 3'd0, 8'd1, 1'b1, MOT_REST, 8'd0, 1'b0, 1'b0);
        // down call below every car: the "car above" bonus, car 0 now busy
        send_beat(OP_HALL, 3'd0, 8'd0, 1'b0, MOT_REST, 8'd0, 1'b0, 1'b0);
        send_beat(OP_HALL, 3'd0, 8'd255, 1'b1, MOT_REST, 8'd0, 1'b0, 1'b0);
        send_beat(OP_HALL, 3'd0, 8'd255, 1'b0, MOT_REST, 8'd0, 1'b0, 1'b0);
        send_beat(OP_UPDATE, 3'd7, 8'd255, 1'b0, MOT_DOWN, 8'd255, 1'b1, 1'b1);
        send_beat(OP_UPDATE, 3'd0, 8'd0, 1'b0, MOT_UP, 8'd0, 1'b1, 1'b1);
        // motion left as it was, riders ignored, busy kept
        send_beat(OP_UPDATE, 3'd2, 8'd128, 1'b0, MOTION_KEEP, 8'd77, 1'b0, 1'b0);
        send_beat(OP_UPDATE, 3'd1, 8'd10, 1'b0, MOT_UP, 8'd5, 1'b1, 1'b1);
        // up call above two cars moving up: both get the bonus, the nearer one wins
        send_beat(OP_HALL, 3'd0, 8'd20, 1'b1, MOT_REST, 8'd0, 1'b0, 1'b0);
        // down call below a car moving down
        send_beat(OP_HALL, 3'd0, 8'd200, 1'b0, MOT_REST, 8'd0, 1'b0, 1'b0);
        send_beat(OP_UPDATE, 3'd4, 8'd50, 1'b0, MOT_REST, 8'd0, 1'b0, 1'b1);
        send_beat(OP_HALL, 3'd0, 8'd40, 1'b0, MOT_REST, 8'd0, 1'b0, 1'b0);
        send_beat(OP_UNUSED, 3'd5, 8'd99, 1'b1, MOT_UP, 8'd12, 1'b1, 1'b1);
        // removed car still takes updates but is skipped by the scan
        send_beat(OP_REMOVE, 3'd6, 8'd0, 1'b0, MOT_REST, 8'd0, 1'b0, 1'b0);
        send_beat(OP_UPDATE, 3'd6, 8'd3, 1'b1, MOT_UP, 8'd9, 1'b1, 1'b1);
        send_beat(OP_HALL, 3'd0, 8'd3, 1'b1, MOT_REST, 8'd0, 1'b0, 1'b0);
        send_beat(OP_UNUSED, 3'd7, 8'd255, 1'b1, MOTION_KEEP, 8'd255, 1'b1, 1'b1);
        send_beat(OP_UPDATE, 3'd3, 8'd255, 1'b1, MOT_DOWN, 8'd255, 1'b1, 1'b1);

        // --- random phases over a range of active counts ---
        random_run(120, 1);
        roll_pressure();
        write_active(4'd1);
        random_run(50, 0);
        roll_pressure();
        write_active(4'd0);             // clamps to one car
        random_run(30, 0);
        roll_pressure();
        write_active(4'd15);            // clamps to the full table
        random_run(60, 3);
        roll_pressure();
        write_active(4'd3);
        random_run(50, 2);
        roll_pressure();
        write_active(4'd9);
        random_run(40, 2);

        // --- round robin: every scanned car out of service ---
        roll_pressure();
        write_active(4'd3);
        send_beat(OP_REMOVE, 3'd0, 8'd0, 1'b0, MOT_REST, 8'd0, 1'b0, 1'b0);
        send_beat(OP_REMOVE, 3'd1, 8'd0, 1'b0, MOT_REST, 8'd0, 1'b0, 1'b0);
        send_beat(OP_REMOVE, 3'd2, 8'd0, 1'b0, MOT_REST, 8'd0, 1'b0, 1'b0);
        random_run(40, 0);

        // --- tail without idling: wide scan, then the whole fleet removed ---
        quiet = 1'b1;
        write_active(4'd8);
        random_run(40, 0);
        for (int c = 3; c < MAX_CARS_DEF; c++)
            send_beat(OP_REMOVE, CAR_W'(c), 8'd0, 1'b0, MOT_REST, 8'd0, 1'b0, 1'b0);
        random_run(30, 0);
        write_active(4'd0);
        random_run(10, 0);

        @(negedge clk);
        req_if.valid = 1'b0;
        while (awaiting != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
